// ----- sv/arq_pkg.sv -----
// Package for the alert retry queue: widths, request and config codes, entry type, saturating add.
// No dependencies.
package arq_pkg;
  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS = 32;
  localparam int ID_BITS = 16;
  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REQ_NONE = 3'd0;
  localparam logic [2:0] REQ_PUSH = 3'd1;
  localparam logic [2:0] REQ_EXPIRE = 3'd2;
  localparam logic [2:0] REQ_MARK = 3'd3;
  localparam logic [2:0] REQ_RESULT = 3'd4;
  localparam logic [2:0] REQ_LOST = 3'd5;

  localparam logic [1:0] OUT_FAILED = 2'd2;

  localparam logic [1:0] CFG_MAX_AGE = 2'd0;
  localparam logic [1:0] CFG_CAPACITY = 2'd1;
  localparam logic [1:0] CFG_BO_INIT = 2'd2;
  localparam logic [1:0] CFG_BO_MAX = 2'd3;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic [2:0] kind;
    logic [TIME_BITS-1:0] trig;
  } entry_t;

  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction
endpackage

// ----- sv/arq_if.sv -----
// Channel interfaces: event in, result out, configuration write.
// Depends on arq_pkg.
interface arq_req_if import arq_pkg::*; ();
  logic valid;
  logic ready;
  logic [2:0] req_type;
  logic [TIME_BITS-1:0] now_time;
  logic online;
  logic [ID_BITS-1:0] alert_id;
  logic [2:0] alert_kind;
  logic [TIME_BITS-1:0] trigger_time;
  logic [1:0] outcome;
  modport source (output valid, req_type, now_time, online, alert_id, alert_kind,
                  trigger_time, outcome, input ready);
  modport sink (input valid, req_type, now_time, online, alert_id, alert_kind,
                trigger_time, outcome, output ready);
endinterface

interface arq_res_if import arq_pkg::*; ();
  logic valid;
  logic ready;
  logic ready_valid;
  logic [ID_BITS-1:0] ready_alert_id;
  logic [2:0] ready_kind;
  logic [TIME_BITS-1:0] ready_trigger_time;
  logic deadline_valid;
  logic [TIME_BITS-1:0] deadline_time;
  logic [CNT_BITS-1:0] queued_count;
  logic awaiting_result;
  logic [CNT_BITS-1:0] removed_count;
  modport source (output valid, ready_valid, ready_alert_id, ready_kind,
                  ready_trigger_time, deadline_valid, deadline_time, queued_count,
                  awaiting_result, removed_count, input ready);
  modport sink (input valid, ready_valid, ready_alert_id, ready_kind,
                ready_trigger_time, deadline_valid, deadline_time, queued_count,
                awaiting_result, removed_count, output ready);
endinterface

interface arq_cfg_if ();
  logic valid;
  logic ready;
  logic [1:0] index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- sv/arq_store.sv -----
// Alert store: one-port-write, one-port-read synchronous RAM.
// Depends on arq_pkg.
module arq_store import arq_pkg::*; (
  input  logic clk,
  input  logic we,
  input  logic [IDX_BITS-1:0] waddr,
  input  entry_t wdata,
  input  logic [IDX_BITS-1:0] raddr,
  output entry_t rdata
);
  entry_t mem [QUEUE_DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- sv/alert_retry_queue.sv -----
// Alert retry queue: sequencer around a registered-read alert store.
// Sequence: none, push, mark, lost and an unmatched result go through act, front
// read and front data to the held result; a matched result reads the front again.
// Expire and a dropping push first walk the queue, reading and then moving or
// dropping each entry. One item at a time: the next item can be taken in the cycle
// after the result is taken.
// Reset (rst, synchronous): empty queue, retry disarmed, registers at defaults.
// Store contents are undefined after reset; only written entries are read.
module alert_retry_queue import arq_pkg::*; (
  input logic clk,
  input logic rst,
  arq_req_if.sink req,
  arq_res_if.source res,
  arq_cfg_if.sink cfg
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD = 4'd1;   // issue read at walk position
  localparam logic [3:0] S_WK = 4'd2;   // entry arrives, move or drop
  localparam logic [3:0] S_ACT = 4'd3;  // act on event
  localparam logic [3:0] S_FR = 4'd4;   // issue front read
  localparam logic [3:0] S_FW = 4'd5;   // front data arrives
  localparam logic [3:0] S_OUT = 4'd6;  // result held

  logic [3:0] state;
  logic [TIME_BITS-1:0] max_age, bo_init, bo_max;
  logic [3:0] capacity;

  logic [IDX_BITS-1:0] head;
  logic [CNT_BITS-1:0] count;
  logic sent, armed;
  logic [TIME_BITS-1:0] retry_time, retry_delay;

  // latched item
  logic [2:0] rq;
  logic [TIME_BITS-1:0] now;
  logic onl;
  entry_t item;
  logic [1:0] oc;

  // walk: rd position, write position
  logic [CNT_BITS-1:0] rpos, wpos;
  logic [CNT_BITS-1:0] removed;
  logic drop_mode;  // push drop: drop exactly entry at start

  logic we;
  logic [IDX_BITS-1:0] waddr, raddr;
  entry_t wdata, rdata;

  arq_store u_store (.clk, .we, .waddr, .wdata, .raddr, .rdata);

  function automatic logic [IDX_BITS-1:0] slot(input logic [IDX_BITS-1:0] h,
                                               input logic [CNT_BITS-1:0] p);
    logic [CNT_BITS:0] s;
    s = {{(CNT_BITS+1-IDX_BITS){1'b0}}, h} + {1'b0, p};
    return s[IDX_BITS-1:0];
  endfunction

  logic old;
  assign old = (now >= rdata.trig) && ((now - rdata.trig) >= max_age);

  logic [CNT_BITS-1:0] start;
  assign start = {{(CNT_BITS-1){1'b0}}, (sent && count != '0)};

  always_comb begin
    we = 1'b0;
    waddr = slot(head, wpos);
    wdata = rdata;
    raddr = slot(head, rpos);
    if (state == S_WK) begin
      we = drop_mode ? (wpos != rpos) : !old;
    end else if (state == S_ACT && rq == REQ_PUSH && count != CNT_BITS'(QUEUE_DEPTH)) begin
      we = 1'b1;
      waddr = slot(head, count);
      wdata = item;
    end
    // keep the front on the read port until the result is taken
    if (state inside {S_FR, S_FW, S_OUT}) raddr = head;
  end

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign res.valid = (state == S_OUT);

  logic [TIME_BITS-1:0] dbl;
  assign dbl = retry_delay[TIME_BITS-1] ? {TIME_BITS{1'b1}} : {retry_delay[TIME_BITS-2:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_age <= 32'd3600000;
      capacity <= 4'd15;
      bo_init <= 32'd1000;
      bo_max <= 32'd300000;
      head <= '0;
      count <= '0;
      sent <= 1'b0;
      armed <= 1'b0;
      retry_time <= '0;
      retry_delay <= 32'd1000;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          CFG_MAX_AGE: max_age <= cfg.data;
          CFG_CAPACITY: capacity <= cfg.data[3:0];
          CFG_BO_INIT: bo_init <= cfg.data;
          CFG_BO_MAX: bo_max <= cfg.data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            rq <= req.req_type;
            now <= req.now_time;
            onl <= req.online;
            item <= '{id: req.alert_id, kind: req.alert_kind, trig: req.trigger_time};
            oc <= req.outcome;
            removed <= '0;
            drop_mode <= 1'b0;
            if (req.req_type == REQ_EXPIRE) begin
              rpos <= start;
              wpos <= start;
              state <= S_RD;
            end else if (req.req_type == REQ_PUSH && count >= {1'b0, capacity}
                         && {{(CNT_BITS-1){1'b0}}, sent} < count) begin
              // drop oldest droppable: shift later entries down by one
              rpos <= {{(CNT_BITS-1){1'b0}}, sent} + 1'b1;
              wpos <= {{(CNT_BITS-1){1'b0}}, sent};
              drop_mode <= 1'b1;
              removed <= CNT_BITS'(1);
              state <= S_RD;
            end else begin
              state <= S_ACT;
            end
          end
        end
        S_RD: begin
          if (rpos >= count) begin
            count <= wpos;
            state <= S_ACT;
          end else begin
            state <= S_WK;
          end
        end
        S_WK: begin
          rpos <= rpos + 1'b1;
          if (drop_mode || !old) wpos <= wpos + 1'b1;
          else removed <= removed + 1'b1;
          state <= S_RD;
        end
        S_ACT: begin
          state <= S_FR;
          case (rq)
            REQ_PUSH: if (count != CNT_BITS'(QUEUE_DEPTH)) count <= count + 1'b1;
            REQ_MARK: if (count != '0) sent <= 1'b1;
            REQ_LOST: if (sent) begin
              sent <= 1'b0;
              armed <= 1'b1;
              retry_time <= sat_add(now, retry_delay);
              retry_delay <= (dbl > bo_max) ? bo_max : dbl;
            end
            default: ;
          endcase
        end
        S_FR: state <= S_FW;
        S_FW: begin
          state <= S_OUT;
          if (rq == REQ_RESULT && sent && count != '0 && rdata.id == item.id
              && rdata.kind == item.kind) begin
            sent <= 1'b0;
            if (oc == OUT_FAILED) begin
              armed <= 1'b1;
              retry_time <= sat_add(now, retry_delay);
              retry_delay <= (dbl > bo_max) ? bo_max : dbl;
            end else begin
              head <= head + 1'b1;
              count <= count - 1'b1;
              retry_delay <= bo_init;
              armed <= 1'b0;
              retry_time <= '0;
            end
            state <= S_FR;  // reread front after the change
            rq <= REQ_NONE;
          end
        end
        S_OUT: if (res.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // result fields from current state and the front entry
  logic rdy;
  logic [TIME_BITS-1:0] expt;
  assign rdy = !sent && onl && count != '0 && !(armed && now < retry_time);
  assign expt = sat_add(rdata.trig, max_age);
  assign res.ready_valid = rdy;
  assign res.ready_alert_id = rdy ? rdata.id : '0;
  assign res.ready_kind = rdy ? rdata.kind : '0;
  assign res.ready_trigger_time = rdy ? rdata.trig : '0;
  assign res.deadline_valid = armed || count != '0;
  assign res.deadline_time = (count != '0) ? ((!armed || expt < retry_time) ? expt : retry_time)
                             : (armed ? retry_time : '0);
  assign res.queued_count = count;
  assign res.awaiting_result = sent;
  assign res.removed_count = removed;
endmodule

// ----- sv/arq_checker.sv -----
// Port-level checker for the alert retry queue, bound to the top level.
// Depends on arq_pkg and the channel interfaces.
module arq_checker import arq_pkg::*; (
  input logic clk,
  input logic rst,
  input logic in_v, in_r, out_v, out_r,
  input logic rv, dv, aw,
  input logic [CNT_BITS-1:0] qc
);
  a_hold: assert property (@(posedge clk) disable iff (rst) out_v && !out_r |=> out_v)
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_r && out_v))
    else $error("item taken while result pending");
  a_take: assert property (@(posedge clk) disable iff (rst) in_v && in_r |=> !in_r)
    else $error("second item taken while one is in progress");
  a_cnt: assert property (@(posedge clk) disable iff (rst) out_v |-> qc <= CNT_BITS'(QUEUE_DEPTH))
    else $error("count beyond depth");
  a_rdy: assert property (@(posedge clk) disable iff (rst) out_v && rv |-> !aw && qc != '0 && dv)
    else $error("ready with inconsistent status");
endmodule

bind alert_retry_queue arq_checker u_chk (
  .clk, .rst, .in_v(req.valid), .in_r(req.ready), .out_v(res.valid), .out_r(res.ready),
  .rv(res.ready_valid), .dv(res.deadline_valid), .aw(res.awaiting_result),
  .qc(res.queued_count)
);
